/* rtl/indexed_min_heap_queue_macros.svh */
// Assertion macros used by the checker file of the indexed min-heap queue
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising clock outside reset
`define IMHQ_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imhq check failed");

// Next-cycle implication, checked on every rising clock outside reset
`define IMHQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imhq check failed");

`endif

/* rtl/imhq_pkg.sv */
// Shared types, constants and control bundles of the indexed min-heap queue
package imhq_pkg;

    localparam int VERTICES_DEF = 1024;
    localparam int VTX_W        = 10;
    localparam int KEY_W        = 32;
    localparam int OCC_W        = 11;

    // opcodes
    localparam logic OP_OFFER   = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // heap read address selects
    typedef logic [2:0] haddr_sel_t;
    localparam haddr_sel_t HA_ZERO   = 3'd0;
    localparam haddr_sel_t HA_POS    = 3'd1;
    localparam haddr_sel_t HA_LAST   = 3'd2;
    localparam haddr_sel_t HA_PARENT = 3'd3;
    localparam haddr_sel_t HA_LEFT   = 3'd4;
    localparam haddr_sel_t HA_RIGHT  = 3'd5;

    typedef struct packed {
        logic [VTX_W-1:0] vert;
        logic [KEY_W-1:0] key;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic       clr_wr;
        logic       in_load;
        logic       vtx_rd;
        logic       heap_rd;
        haddr_sel_t haddr;
        logic       mv_from_in;
        logic       mv_from_ram;
        logic       idx_from_pos;
        logic       idx_from_fill;
        logic       ins_new;
        logic       ext_top;
        logic       held_set;
        logic       left_keep;
        logic       up_step;
        logic       dn_step;
        logic       dn_right;
        logic       place;
        logic       res_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic op_extract;
        logic vtx_ok;
        logic flag;
        logic pos_ok;
        logic full;
        logic empty;
        logic last_one;
        logic key_less;
        logic idx_zero;
        logic up_less;
        logic has_left;
        logic has_right;
        logic dn_move_l;
        logic dn_move_r;
        logic out_busy;
    } dp_sts_t;

endpackage

/* rtl/imhq_ram.sv */
// Generic single-write, single-read RAM with registered read data
module imhq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds its value between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/imhq_ctrl.sv */
// Sequencer of the indexed min-heap queue: clearing pass, offer, sift-up, extract, sift-down
module imhq_ctrl
    import imhq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_OF_LK  = 4'd3;
    localparam logic [3:0] S_OF_CMP = 4'd4;
    localparam logic [3:0] S_UP     = 4'd5;
    localparam logic [3:0] S_UP_CMP = 4'd6;
    localparam logic [3:0] S_EX_TOP = 4'd7;
    localparam logic [3:0] S_EX_LST = 4'd8;
    localparam logic [3:0] S_DN     = 4'd9;
    localparam logic [3:0] S_DN_L   = 4'd10;
    localparam logic [3:0] S_DN_R   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.op_extract)
                begin
                    if (sts.empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.heap_rd = 1'b1;
                        cmd.haddr   = HA_ZERO;
                        state_next  = S_EX_TOP;
                    end
                end
                else if (sts.vtx_ok)
                begin
                    cmd.vtx_rd = 1'b1;
                    state_next = S_OF_LK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_OF_LK:
            begin
                if (sts.flag)
                begin
                    cmd.held_set     = 1'b1;
                    cmd.idx_from_pos = 1'b1;
                    if (sts.pos_ok)
                    begin
                        cmd.heap_rd = 1'b1;
                        cmd.haddr   = HA_POS;
                        state_next  = S_OF_CMP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!sts.full)
                begin
                    cmd.mv_from_in    = 1'b1;
                    cmd.idx_from_fill = 1'b1;
                    cmd.ins_new       = 1'b1;
                    state_next        = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_OF_CMP:
            begin
                if (sts.key_less)
                begin
                    cmd.mv_from_in = 1'b1;
                    state_next     = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UP:
            begin
                if (sts.idx_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.heap_rd = 1'b1;
                    cmd.haddr   = HA_PARENT;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_less)
                begin
                    cmd.up_step = 1'b1;
                    state_next  = S_UP;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_EX_TOP:
            begin
                cmd.ext_top = 1'b1;
                if (sts.last_one)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.heap_rd = 1'b1;
                    cmd.haddr   = HA_LAST;
                    state_next  = S_EX_LST;
                end
            end
            S_EX_LST:
            begin
                cmd.mv_from_ram = 1'b1;
                state_next      = S_DN;
            end
            S_DN:
            begin
                if (sts.has_left)
                begin
                    cmd.heap_rd = 1'b1;
                    cmd.haddr   = HA_LEFT;
                    state_next  = S_DN_L;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_L:
            begin
                cmd.left_keep = 1'b1;
                if (sts.has_right)
                begin
                    cmd.heap_rd = 1'b1;
                    cmd.haddr   = HA_RIGHT;
                    state_next  = S_DN_R;
                end
                else if (sts.dn_move_l)
                begin
                    cmd.dn_step = 1'b1;
                    state_next  = S_DN;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_R:
            begin
                if (sts.dn_move_r)
                begin
                    cmd.dn_step  = 1'b1;
                    cmd.dn_right = 1'b1;
                    state_next   = S_DN;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/imhq_dp.sv */
// Datapath of the indexed min-heap queue: heap and position RAMs, index and entry registers
module imhq_dp
    import imhq_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  logic             opcode,
    input  logic [VTX_W-1:0] vertex_id,
    input  logic [KEY_W-1:0] priority_req,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [VTX_W-1:0] min_vertex,
    output logic [KEY_W-1:0] min_priority,
    output logic             extracted,
    output logic             was_held,
    output logic             now_empty,
    output logic [OCC_W-1:0] occupancy
);

    localparam int SW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);
    localparam int IW = SW + 2;
    localparam int HW = $bits(slot_t);

    // control registers
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;

    // item and walk registers
    logic             op_reg;
    logic [VTX_W-1:0] v_reg;
    logic [KEY_W-1:0] key_reg;
    logic [SW-1:0]    idx_reg;
    slot_t            mv_reg;
    slot_t            left_reg;
    logic             left_less_reg;
    logic             res_ext_reg;
    logic             res_held_reg;
    slot_t            res_reg;

    // output registers
    logic [VTX_W-1:0] o_vert_reg;
    logic [KEY_W-1:0] o_key_reg;
    logic             o_ext_reg;
    logic             o_held_reg;
    logic             o_empty_reg;
    logic [OCC_W-1:0] o_occ_reg;

    // RAM ports
    logic          h_we, h_re, v_we, v_re;
    logic [SW-1:0] h_waddr, h_raddr, v_waddr, v_raddr;
    slot_t         h_wdata, hq;
    logic [HW-1:0] h_rbits;
    logic [SW:0]   v_wdata, v_rbits;

    logic [IW-1:0] lft, rgt, fill_ext;
    logic [SW-1:0] par;
    logic [CW-1:0] fill_m1;
    logic          right_wins;
    slot_t         child;
    logic [SW-1:0] child_idx;

    imhq_ram #(.WIDTH(HW), .DEPTH(VERTICES)) u_heap_ram
    (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rbits)
    );

    imhq_ram #(.WIDTH(SW + 1), .DEPTH(VERTICES)) u_pos_ram
    (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_rbits)
    );

    assign hq = slot_t'(h_rbits);

    // index arithmetic
    assign lft      = {1'b0, idx_reg, 1'b1};
    assign rgt      = {1'b0, idx_reg, 1'b0} + IW'(2);
    assign fill_ext = IW'(fill_reg);
    assign par      = (idx_reg - SW'(1)) >> 1;
    assign fill_m1  = fill_reg - CW'(1);

    // child chosen on a downward step; left wins ties
    assign right_wins = cmd.dn_right &&
                        (hq.key < (left_less_reg ? left_reg.key : mv_reg.key));
    assign child      = (cmd.dn_right && !right_wins) ? left_reg : hq;
    assign child_idx  = right_wins ? rgt[SW-1:0] : lft[SW-1:0];

    // heap read address
    always_comb
    begin
        h_re = cmd.heap_rd;
        unique case (cmd.haddr)
            HA_ZERO:   h_raddr = '0;
            HA_POS:    h_raddr = v_rbits[SW-1:0];
            HA_LAST:   h_raddr = fill_m1[SW-1:0];
            HA_PARENT: h_raddr = par;
            HA_LEFT:   h_raddr = lft[SW-1:0];
            HA_RIGHT:  h_raddr = rgt[SW-1:0];
            default:   h_raddr = '0;
        endcase
    end

    // heap write: the moving entry lands, or a neighbour shifts into the hole
    always_comb
    begin
        h_we    = cmd.place | cmd.up_step | cmd.dn_step;
        h_waddr = idx_reg;
        priority if (cmd.place)
            h_wdata = mv_reg;
        else if (cmd.up_step)
            h_wdata = hq;
        else
            h_wdata = child;
    end

    // position RAM: {queued, slot} per vertex
    assign v_re    = cmd.vtx_rd;
    assign v_raddr = SW'(v_reg);
    always_comb
    begin
        v_we = cmd.clr_wr | cmd.ext_top | cmd.place | cmd.up_step | cmd.dn_step;
        priority if (cmd.clr_wr)
            v_waddr = clr_reg[SW-1:0];
        else if (cmd.ext_top)
            v_waddr = SW'(hq.vert);
        else if (cmd.place)
            v_waddr = SW'(mv_reg.vert);
        else if (cmd.up_step)
            v_waddr = SW'(hq.vert);
        else
            v_waddr = SW'(child.vert);
        v_wdata = (cmd.clr_wr || cmd.ext_top) ? '0 : {1'b1, idx_reg};
    end

    // next values of control registers
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.ins_new)
            fill_next = fill_reg + CW'(1);
        else if (cmd.ext_top)
            fill_next = fill_m1;
        clr_next       = cmd.clr_wr ? (clr_reg + CW'(1)) : clr_reg;
        out_valid_next = cmd.res_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg       <= opcode;
            v_reg        <= vertex_id;
            key_reg      <= priority_req;
            res_ext_reg  <= 1'b0;
            res_held_reg <= 1'b0;
            res_reg      <= '0;
        end
        if (cmd.held_set)
            res_held_reg <= 1'b1;
        if (cmd.ext_top)
        begin
            res_ext_reg <= 1'b1;
            res_reg     <= hq;
        end
        if (cmd.mv_from_in)
        begin
            mv_reg.vert <= v_reg;
            mv_reg.key  <= key_reg;
        end
        if (cmd.mv_from_ram)
            mv_reg <= hq;
        if (cmd.left_keep)
        begin
            left_reg      <= hq;
            left_less_reg <= (hq.key < mv_reg.key);
        end
        priority if (cmd.idx_from_pos)
            idx_reg <= v_rbits[SW-1:0];
        else if (cmd.idx_from_fill)
            idx_reg <= fill_reg[SW-1:0];
        else if (cmd.mv_from_ram)
            idx_reg <= '0;
        else if (cmd.up_step)
            idx_reg <= par;
        else if (cmd.dn_step)
            idx_reg <= child_idx;
        else
            idx_reg <= idx_reg;
        if (cmd.res_load)
        begin
            o_vert_reg  <= res_reg.vert;
            o_key_reg   <= res_reg.key;
            o_ext_reg   <= res_ext_reg;
            o_held_reg  <= res_held_reg;
            o_empty_reg <= (fill_reg == '0);
            o_occ_reg   <= OCC_W'(fill_reg);
        end
    end

    // status towards the sequencer
    always_comb
    begin
        sts.clr_last   = (clr_reg == CW'(VERTICES - 1));
        sts.op_extract = (op_reg == OP_EXTRACT);
        sts.vtx_ok     = (int'(v_reg) < VERTICES);
        sts.flag       = v_rbits[SW];
        sts.pos_ok     = (IW'(v_rbits[SW-1:0]) < fill_ext);
        sts.full       = (fill_reg == CW'(VERTICES));
        sts.empty      = (fill_reg == '0);
        sts.last_one   = (fill_reg == CW'(1));
        sts.key_less   = (key_reg < hq.key);
        sts.idx_zero   = (idx_reg == '0);
        sts.up_less    = (mv_reg.key < hq.key);
        sts.has_left   = (lft < fill_ext);
        sts.has_right  = (rgt < fill_ext);
        sts.dn_move_l  = (hq.key < mv_reg.key);
        sts.dn_move_r  = left_less_reg || (hq.key < mv_reg.key);
        sts.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign min_vertex   = o_vert_reg;
    assign min_priority = o_key_reg;
    assign extracted    = o_ext_reg;
    assign was_held     = o_held_reg;
    assign now_empty    = o_empty_reg;
    assign occupancy    = o_occ_reg;

endmodule

/* rtl/indexed_min_heap_queue.sv */
// Indexed binary min-heap priority queue with insert, decrease-key and extract-min.
// One item is worked at a time. After reset a clearing pass writes every entry of
// the per-vertex position RAM empty; no item is taken until it ends. An offer for
// an ignored vertex and an extract on an empty queue go straight to the result;
// otherwise an offer climbs and an extract sinks one heap level per step. The walk
// is paced by the single read port of the heap RAM, which serves one parent or
// child read per step. A new item is taken only once the sequencer is back in idle.
// A finished result sits in an output register while the next item is taken; a
// stalled result holds the queue in its last step until the receiver takes it.
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             opcode,
    input  logic [VTX_W-1:0] vertex_id,
    input  logic [KEY_W-1:0] priority_req,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [VTX_W-1:0] min_vertex,
    output logic [KEY_W-1:0] min_priority,
    output logic             extracted,
    output logic             was_held,
    output logic             now_empty,
    output logic [OCC_W-1:0] occupancy
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    imhq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    imhq_dp #(.VERTICES(VERTICES)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .vertex_id    (vertex_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .min_vertex   (min_vertex),
        .min_priority (min_priority),
        .extracted    (extracted),
        .was_held     (was_held),
        .now_empty    (now_empty),
        .occupancy    (occupancy)
    );

endmodule

/* rtl/imhq_checker.sv */
// Port-level checks of the indexed min-heap queue, bound to the top level
`include "indexed_min_heap_queue_macros.svh"

module imhq_checker
    import imhq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             opcode,
    input logic [VTX_W-1:0] vertex_id,
    input logic [KEY_W-1:0] priority_req,
    input logic             out_valid,
    input logic             out_stall,
    input logic [VTX_W-1:0] min_vertex,
    input logic [KEY_W-1:0] min_priority,
    input logic             extracted,
    input logic             was_held,
    input logic             now_empty,
    input logic [OCC_W-1:0] occupancy
);

    // a stalled input beat keeps its payload
    `IMHQ_ASSERT_NXT(a_in_hold, in_valid && in_stall,
        in_valid && $stable(opcode) && $stable(vertex_id) && $stable(priority_req))

    // a stalled result beat holds
    `IMHQ_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(min_vertex) && $stable(min_priority) && $stable(occupancy))

    // empty flag agrees with the count
    `IMHQ_ASSERT(a_empty_cnt, out_valid, now_empty == (occupancy == '0))

    // an extract never reports a held vertex, and leaves room for the removed entry
    `IMHQ_ASSERT(a_ext_held, out_valid && extracted, !was_held && (occupancy < OCC_W'(1024)))

    // no removal means zero payload
    `IMHQ_ASSERT(a_no_ext_zero, out_valid && !extracted,
        (min_vertex == '0) && (min_priority == '0))

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (.*);

/* sim/indexed_min_heap_queue_tb.sv */
// Self-checking testbench of the indexed min-heap queue with a scoreboard heap model
`timescale 1ns / 100ps

module indexed_min_heap_queue_tb;
    import imhq_pkg::*;

    localparam int NV        = VERTICES_DEF;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 100;

    typedef struct {
        logic [VTX_W-1:0] mv;
        logic [KEY_W-1:0] mp;
        logic             ext;
        logic             held;
        logic             empty;
        logic [OCC_W-1:0] occ;
    } heap_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             opcode;
    logic [VTX_W-1:0] vertex_id;
    logic [KEY_W-1:0] priority_req;
    logic             out_valid;
    logic             out_stall;
    logic [VTX_W-1:0] min_vertex;
    logic [KEY_W-1:0] min_priority;
    logic             extracted;
    logic             was_held;
    logic             now_empty;
    logic [OCC_W-1:0] occupancy;

    // scoreboard copy of the queue
    logic [VTX_W-1:0] mdl_vert [NV];
    logic [KEY_W-1:0] mdl_key  [NV];
    int               mdl_pos  [NV];
    bit               mdl_in   [NV];
    int               mdl_fill;

    heap_result_t pending_results[$];
    int  fail_count;
    int  beats_sent;
    int  beats_checked;
    int  extract_hits;
    int  held_hits;
    int  cycle_count;
    bit  hold_rx;

    indexed_min_heap_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .vertex_id(vertex_id), .priority_req(priority_req),
        .out_valid(out_valid), .out_stall(out_stall),
        .min_vertex(min_vertex), .min_priority(min_priority),
        .extracted(extracted), .was_held(was_held),
        .now_empty(now_empty), .occupancy(occupancy)
    );

    always #10 clk = ~clk;

    // swap two heap slots and keep the position table in step
    function automatic void slot_swap(int a, int b);
        logic [VTX_W-1:0] tv;
        logic [KEY_W-1:0] tk;
        tv = mdl_vert[a];
        tk = mdl_key[a];
        mdl_vert[a] = mdl_vert[b];
        mdl_key[a] = mdl_key[b];
        mdl_vert[b] = tv;
        mdl_key[b] = tk;
        mdl_pos[mdl_vert[a]] = a;
        mdl_pos[mdl_vert[b]] = b;
    endfunction

    function automatic void climb(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (mdl_key[i] < mdl_key[p])
            begin
                slot_swap(i, p);
                i = p;
            end
            else
                break;
        end
    endfunction

    function automatic void sink(int i);
        int best;
        int l;
        int r;
        forever
        begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < mdl_fill && mdl_key[l] < mdl_key[best])
                best = l;
            if (r < mdl_fill && mdl_key[r] < mdl_key[best])
                best = r;
            if (best == i)
                break;
            slot_swap(i, best);
            i = best;
        end
    endfunction

    // work out the result of one beat and update the copy
    function automatic heap_result_t predict_queue(logic op, logic [VTX_W-1:0] v,
                                                   logic [KEY_W-1:0] k);
        heap_result_t r;
        int s;
        r = '{default: '0};
        if (op == OP_OFFER)
        begin
            if (mdl_in[v])
            begin
                s = mdl_pos[v];
                r.held = 1'b1;
                if (s < mdl_fill && k < mdl_key[s])
                begin
                    mdl_key[s] = k;
                    climb(s);
                end
            end
            else if (mdl_fill < NV)
            begin
                s = mdl_fill;
                mdl_fill++;
                mdl_vert[s] = v;
                mdl_key[s] = k;
                mdl_pos[v] = s;
                mdl_in[v] = 1'b1;
                climb(s);
            end
        end
        else if (mdl_fill > 0)
        begin
            r.mv = mdl_vert[0];
            r.mp = mdl_key[0];
            r.ext = 1'b1;
            mdl_in[mdl_vert[0]] = 1'b0;
            mdl_fill--;
            if (mdl_fill > 0)
            begin
                mdl_vert[0] = mdl_vert[mdl_fill];
                mdl_key[0] = mdl_key[mdl_fill];
                mdl_pos[mdl_vert[0]] = 0;
                sink(0);
            end
        end
        r.empty = (mdl_fill == 0);
        r.occ = mdl_fill[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH beat %0d %s: got %0h want %0h", beats_checked, what, got, want);
        fail_count++;
    endtask

    // send one beat, sometimes after a gap; valid stays up into the next beat of a burst
    task automatic send_beat(logic op, logic [VTX_W-1:0] v, logic [KEY_W-1:0] k);
        heap_result_t r;
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        vertex_id <= v;
        priority_req <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_queue(op, v, k);
        pending_results.insert(pending_results.size(), r);
        beats_sent++;
        @(negedge clk);
    endtask

    // end the burst and wait for every expected result
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // pick a vertex that is currently queued, or any one when none are
    function automatic logic [VTX_W-1:0] queued_vertex();
        if (mdl_fill == 0)
            return VTX_W'($urandom_range(0, NV - 1));
        return mdl_vert[$urandom_range(0, mdl_fill - 1)];
    endfunction

    task automatic test_directed();
        send_beat(OP_EXTRACT, 10'h3FF, 32'hFFFF_FFFF);   // extract while empty
        send_beat(OP_OFFER, 10'd0, 32'hFFFF_FFFF);
        send_beat(OP_OFFER, 10'h3FF, 32'd0);
        send_beat(OP_OFFER, 10'd5, 32'd100);
        send_beat(OP_OFFER, 10'd6, 32'd100);             // tie
        send_beat(OP_OFFER, 10'd7, 32'd100);
        send_beat(OP_OFFER, 10'd5, 32'd100);             // held, equal key
        send_beat(OP_OFFER, 10'd5, 32'd200);             // held, larger key
        send_beat(OP_OFFER, 10'd0, 32'd1);               // decrease to near root
        send_beat(OP_OFFER, 10'h2AA, 32'h5555_5555);
        send_beat(OP_OFFER, 10'h155, 32'hAAAA_AAAA);
        repeat (12)
            send_beat(OP_EXTRACT, VTX_W'($urandom), KEY_W'($urandom));
        wait_drained();
    endtask

    // fill deep, decrease keys, drain to empty
    task automatic test_fill_and_drain();
        repeat (300)
            send_beat(OP_OFFER, VTX_W'($urandom), KEY_W'($urandom_range(0, 5000)));
        repeat (60)
            send_beat(OP_OFFER, queued_vertex(), KEY_W'($urandom_range(0, 3000)));
        wait_drained();
        while (mdl_fill > 0)
            send_beat(OP_EXTRACT, VTX_W'($urandom), KEY_W'($urandom));
        send_beat(OP_EXTRACT, '0, '0);
    endtask

    // mixed traffic with small key range to force ties
    task automatic test_random_mix();
        logic [KEY_W-1:0] k;
        int sel;
        repeat (500)
        begin
            sel = $urandom_range(0, 9);
            k = ($urandom_range(0, 1) != 0) ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom);
            if (sel < 4)
                send_beat(OP_OFFER, VTX_W'($urandom), k);
            else if (sel < 6)
                send_beat(OP_OFFER, queued_vertex(), k);
            else
                send_beat(OP_EXTRACT, VTX_W'($urandom), KEY_W'($urandom));
        end
    endtask

    // receiver stall pattern: alternating stall-free and stalling stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_rx)
            out_stall <= ($urandom_range(0, 1) == 0);
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        hold_rx = 1'b0;
        forever
        begin
            repeat ($urandom_range(50, 400)) @(posedge clk);
            hold_rx = ~hold_rx;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        heap_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("UNEXPECTED result beat");
                fail_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (min_vertex !== w.mv)
                    report_mismatch("min_vertex", min_vertex, w.mv);
                if (min_priority !== w.mp)
                    report_mismatch("min_priority", min_priority, w.mp);
                if (extracted !== w.ext)
                    report_mismatch("extracted", extracted, w.ext);
                if (was_held !== w.held)
                    report_mismatch("was_held", was_held, w.held);
                if (now_empty !== w.empty)
                    report_mismatch("now_empty", now_empty, w.empty);
                if (occupancy !== w.occ)
                    report_mismatch("occupancy", occupancy, w.occ);
                if (w.ext)
                    extract_hits++;
                if (w.held)
                    held_hits++;
            end
            beats_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYC)
        begin
            $display("Timeout with %0d results outstanding", pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_OFFER;
        vertex_id = '0;
        priority_req = '0;
        fail_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        extract_hits = 0;
        held_hits = 0;
        cycle_count = 0;
        mdl_fill = 0;
        for (int i = 0; i < NV; i++)
        begin
            mdl_in[i] = 1'b0;
            mdl_pos[i] = 0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_mix();

        wait_drained();
        repeat (DRAIN_CYC) @(negedge clk);
        $display("Sent %0d beats, checked %0d results: %0d extracts, %0d held offers",
                 beats_sent, beats_checked, extract_hits, held_hits);
        $display("Covered empty extract, ties, decrease-key and full drain; %0d mismatches",
                 fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
